// ----- hdl/frc_pkg.sv -----
`timescale 1ns / 1ps

package frc_pkg;

  // number of cache entries in the chain
  localparam int unsigned ENTRIES = 8;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 32;

  // request commands
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // one cache entry as it travels along the chain
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

// ----- hdl/frc_cell.sv -----
`timescale 1ns / 1ps

module frc_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift,
  input  frc_pkg::entry_t              entry_in,
  input  logic [frc_pkg::KEY_W-1:0]    lookup_key,
  output frc_pkg::entry_t              entry_out,
  output logic                         match
);

  logic                         valid_r;
  logic [frc_pkg::KEY_W-1:0]    key_r;
  logic [frc_pkg::VALUE_W-1:0]  value_r;

  // valid bit, cleared at reset, follows the neighbour on a shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= entry_in.valid;
    end
  end

  // key and value move one cell towards the old end on a shift
  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= entry_in.key;
      value_r <= entry_in.value;
    end
  end

  // local compare against the looked-up key
  assign match = valid_r && (key_r == lookup_key);

  assign entry_out.valid = valid_r;
  assign entry_out.key   = key_r;
  assign entry_out.value = value_r;

endmodule

// ----- hdl/fifo_replacement_cache_unit.sv -----
`timescale 1ns / 1ps

// Fully associative key/value cache of frc_pkg::ENTRIES entries with first-in
// first-out replacement. Entries sit in a row of cells, newest at cell 0 and
// oldest at the far end; a miss pushes the new pair into cell 0 and shifts the
// row by one, so a full row drops its oldest pair off the end. Start is taken
// whenever it is high (busy is always low) and the result appears on the out_
// ports, marked by out_strobe, in the following cycle, for that cycle only. The
// key compare across all cells and the value select are combinational and run
// in parallel. The receiver cannot stall
// the block, so results must be captured in the cycle they are shown.
module fifo_replacement_cache_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_command,
  input  logic [frc_pkg::KEY_W-1:0]       in_key,
  input  logic [frc_pkg::VALUE_W-1:0]     in_fill_value,
  output logic                            out_strobe,
  output logic [frc_pkg::VALUE_W-1:0]     out_result_value,
  output logic                            out_hit,
  output logic                            out_evicted,
  output logic [frc_pkg::COUNT_W-1:0]     out_request_total,
  output logic [frc_pkg::COUNT_W-1:0]     out_hit_total
);

  frc_pkg::entry_t                   chain_w [frc_pkg::ENTRIES+1];
  logic [frc_pkg::ENTRIES-1:0]       match_w;
  logic                              accept;
  logic                              access;
  logic                              any_hit;
  logic                              shift;
  logic [frc_pkg::VALUE_W-1:0]       hit_value;

  logic                              strobe_r;
  logic [frc_pkg::VALUE_W-1:0]       value_r;
  logic [frc_pkg::VALUE_W-1:0]       value_nxt;
  logic                              hit_r;
  logic                              evicted_r;
  logic                              evicted_nxt;
  logic [frc_pkg::COUNT_W-1:0]       requests_r;
  logic [frc_pkg::COUNT_W-1:0]       requests_nxt;
  logic [frc_pkg::COUNT_W-1:0]       hits_r;
  logic [frc_pkg::COUNT_W-1:0]       hits_nxt;

  // one request a cycle, never back-pressured
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign access = accept && (in_command == frc_pkg::CMD_ACCESS);

  // new pair enters at the head of the chain
  assign chain_w[0].valid = 1'b1;
  assign chain_w[0].key   = in_key;
  assign chain_w[0].value = in_fill_value;

  // row of cells
  for (genvar i = 0; i < frc_pkg::ENTRIES; i++) begin : g_cell
    frc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift      (shift),
      .entry_in   (chain_w[i]),
      .lookup_key (in_key),
      .entry_out  (chain_w[i+1]),
      .match      (match_w[i])
    );
  end

  // keys are unique, so the matching value is an or of masked values
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < frc_pkg::ENTRIES; i++) begin
      hit_value = hit_value | (chain_w[i+1].value & {frc_pkg::VALUE_W{match_w[i]}});
    end
  end

  assign any_hit = |match_w;
  assign shift   = access && !any_hit;

  // result and counter next values
  always_comb begin
    value_nxt    = '0;
    evicted_nxt  = 1'b0;
    requests_nxt = requests_r;
    hits_nxt     = hits_r;
    if (accept) begin
      if (in_command == frc_pkg::CMD_CLEAR) begin
        requests_nxt = '0;
        hits_nxt     = '0;
      end else begin
        requests_nxt = requests_r + 1'b1;
        if (any_hit) begin
          value_nxt = hit_value;
          hits_nxt  = hits_r + 1'b1;
        end else begin
          value_nxt   = in_fill_value;
          evicted_nxt = chain_w[frc_pkg::ENTRIES].valid;
        end
      end
    end
  end

  // counters and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r   <= 1'b0;
      requests_r <= '0;
      hits_r     <= '0;
    end else begin
      strobe_r   <= accept;
      requests_r <= requests_nxt;
      hits_r     <= hits_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      value_r   <= value_nxt;
      hit_r     <= access && any_hit;
      evicted_r <= evicted_nxt;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_result_value  = value_r;
  assign out_hit           = hit_r;
  assign out_evicted       = evicted_r;
  assign out_request_total = requests_r;
  assign out_hit_total     = hits_r;

  // at most one cell holds a given key
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_w))
    else $error("more than one cell matched the key");

  // a request always gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("request without result");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_hit && out_evicted))
    else $error("hit reported together with eviction");

  // a clear request zeroes both totals
  a_clear_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == frc_pkg::CMD_CLEAR) |=>
      (out_request_total == '0 && out_hit_total == '0))
    else $error("clear did not zero the counters");

  // eviction only happens with the chain full before the shift
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (access && !any_hit && !chain_w[frc_pkg::ENTRIES].valid) |=> !out_evicted)
    else $error("eviction with free cells");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RANDOM_REQUESTS = 1500;
  localparam int unsigned POOL_SIZE       = 12;

  // one result as it appears on the out_ ports
  typedef struct packed {
    logic [frc_pkg::VALUE_W-1:0] value;
    logic                        hit;
    logic                        evicted;
    logic [frc_pkg::COUNT_W-1:0] request_total;
    logic [frc_pkg::COUNT_W-1:0] hit_total;
  } cache_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        in_command = frc_pkg::CMD_ACCESS;
  logic [frc_pkg::KEY_W-1:0]   in_key = '0;
  logic [frc_pkg::VALUE_W-1:0] in_fill_value = '0;
  logic                        out_strobe;
  logic [frc_pkg::VALUE_W-1:0] out_result_value;
  logic                        out_hit;
  logic                        out_evicted;
  logic [frc_pkg::COUNT_W-1:0] out_request_total;
  logic [frc_pkg::COUNT_W-1:0] out_hit_total;

  // shadow copy of the cache: circular buffer, oldest pair at head_slot
  logic [frc_pkg::KEY_W-1:0]   shadow_keys [frc_pkg::ENTRIES];
  logic [frc_pkg::VALUE_W-1:0] shadow_values [frc_pkg::ENTRIES];
  int unsigned                 head_slot = 0;
  int unsigned                 fill_count = 0;
  logic [frc_pkg::COUNT_W-1:0] access_count = '0;
  logic [frc_pkg::COUNT_W-1:0] hit_count = '0;

  cache_result_t      pending_results[$];
  int unsigned        fail_count = 0;
  bit                 gaps_on = 1'b1;

  fifo_replacement_cache_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_key            (in_key),
    .in_fill_value     (in_fill_value),
    .out_strobe        (out_strobe),
    .out_result_value  (out_result_value),
    .out_hit           (out_hit),
    .out_evicted       (out_evicted),
    .out_request_total (out_request_total),
    .out_hit_total     (out_hit_total)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("FAIL fifo_replacement_cache_unit");
    $finish;
  end

  // work out the result of one request and update the shadow state
  function automatic cache_result_t predict_lookup(logic cmd,
                                                   logic [frc_pkg::KEY_W-1:0] key,
                                                   logic [frc_pkg::VALUE_W-1:0] fill);
    cache_result_t r;
    int unsigned   s;
    bit            found;
    r = '0;
    found = 1'b0;
    if (cmd == frc_pkg::CMD_CLEAR) begin
      access_count = '0;
      hit_count = '0;
    end else begin
      access_count = access_count + 1'b1;
      // oldest matching pair wins
      for (int unsigned i = 0; i < fill_count; i++) begin
        s = (head_slot + i) % frc_pkg::ENTRIES;
        if (!found && shadow_keys[s] == key) begin
          found = 1'b1;
          r.value = shadow_values[s];
        end
      end
      if (found) begin
        r.hit = 1'b1;
        hit_count = hit_count + 1'b1;
      end else begin
        // full: drop the oldest pair first
        if (fill_count >= frc_pkg::ENTRIES) begin
          fill_count = frc_pkg::ENTRIES - 1;
          head_slot = (head_slot + 1) % frc_pkg::ENTRIES;
          r.evicted = 1'b1;
        end
        s = (head_slot + fill_count) % frc_pkg::ENTRIES;
        shadow_keys[s] = key;
        shadow_values[s] = fill;
        fill_count++;
        r.value = fill;
      end
    end
    r.request_total = access_count;
    r.hit_total = hit_count;
    return r;
  endfunction

  // present one request and hold it until taken; start stays high on return
  task automatic send_request(logic cmd, logic [frc_pkg::KEY_W-1:0] key,
                              logic [frc_pkg::VALUE_W-1:0] fill);
    if (gaps_on && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_key        <= key;
    in_fill_value <= fill;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_lookup(cmd, key, fill));
  endtask

  // stop sending until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(cache_result_t want);
    check_field("result_value", want.value, out_result_value);
    check_field("hit", want.hit, out_hit);
    check_field("evicted", want.evicted, out_evicted);
    check_field("request_total", want.request_total, out_request_total);
    check_field("hit_total", want.hit_total, out_hit_total);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        check_result(pending_results.pop_front());
      end
    end
  end

  // key and value extremes, hits after misses, clear keeps the contents
  task automatic test_extremes_and_clear();
    send_request(frc_pkg::CMD_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(frc_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(frc_pkg::CMD_ACCESS, 32'h0000_0000, 32'h1234_5678);
    send_request(frc_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(frc_pkg::CMD_CLEAR, $urandom, $urandom);
    send_request(frc_pkg::CMD_ACCESS, 32'h0000_0000, 32'h0000_0000);
    send_request(frc_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // fill to capacity, then evict in arrival order
  task automatic test_fill_and_evict();
    for (int unsigned i = 0; i < frc_pkg::ENTRIES - 2; i++)
      send_request(frc_pkg::CMD_ACCESS, 32'hA5A5_A5A5 + i, 32'h5A5A_0000 + i);
    // full now: a new key drops the zero key, then the all-ones key
    send_request(frc_pkg::CMD_ACCESS, 32'h8000_0001, 32'hDEAD_BEEF);
    send_request(frc_pkg::CMD_ACCESS, 32'h0000_0000, 32'h0F0F_0F0F);
    send_request(frc_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'hF0F0_F0F0);
    send_request(frc_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(frc_pkg::CMD_ACCESS, 32'hA5A5_A5A6, 32'h0000_0002);
    send_request(frc_pkg::CMD_ACCESS, 32'hA5A5_A5A5, 32'h0000_0003);
    drain_results();
  endtask

  // mostly keys from a small pool so hits and evictions mix
  task automatic test_random_traffic(int unsigned count);
    logic [frc_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    logic [frc_pkg::KEY_W-1:0] key;
    logic                      cmd;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 250 == 0) begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      // long stretch without gaps, and one full drain midway
      gaps_on = !(n >= 600 && n < 900);
      if (n == 750) drain_results();
      cmd = ($urandom_range(99) < 3) ? frc_pkg::CMD_CLEAR : frc_pkg::CMD_ACCESS;
      key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      send_request(cmd, key, $urandom);
    end
    drain_results();
  endtask

  // sequence of tests
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes_and_clear();
    test_fill_and_evict();
    test_random_traffic(RANDOM_REQUESTS);
    repeat (5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("PASS fifo_replacement_cache_unit");
    else
      $display("FAIL fifo_replacement_cache_unit");
    $finish;
  end

endmodule
